/* hw/rtl/buddy_block_allocator_top_defines.svh */
// assertion macros for the buddy block allocator
// used by the engine; simulation only, empty under synthesis
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("bba check failed");
`define BBA_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("bba check failed");
`else
`define BBA_ASSERT(lbl, clk, rst, prop)
`define BBA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

/* hw/rtl/bba_pkg.sv */
// shared types and constants of the buddy block allocator
// no dependencies
package bba_pkg;
   localparam int MAX_BLOCKS = 32;
   localparam int OWNER_BITS = 16;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam logic [4:0] ORDER_RESET = 5'd10;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NO_FIT  = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_INVALID = 2'd3
   } status_type;

   typedef struct packed {
      logic [4:0]            order;
      logic [OWNER_BITS-1:0] owner;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } ram_req_type;
endpackage

/* hw/rtl/bba_req_if.sv */
// request channel: valid/ready and one request word
// depends on nothing
interface bba_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] owner_id;
   logic [30:0] request_size;
   modport source (output valid, action, owner_id, request_size, input ready);
   modport sink (input valid, action, owner_id, request_size, output ready);
endinterface

/* hw/rtl/bba_rsp_if.sv */
// response channel: valid/ready and one response word
// depends on nothing
interface bba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [4:0]  block_index;
   logic [4:0]  block_order;
   logic [15:0] block_owner;
   logic [5:0]  block_total;
   logic        last;
   modport source (output valid, status, block_index, block_order, block_owner,
                   block_total, last, input ready);
   modport sink (input valid, status, block_index, block_order, block_owner,
                 block_total, last, output ready);
endinterface

/* hw/rtl/bba_ram.sv */
// block list memory: one write port, one read port, registered read
// depends on bba_pkg
module bba_ram (
   input  logic                 clock,
   input  bba_pkg::ram_req_type ram_req,
   output bba_pkg::entry_type   rdata
);
   import bba_pkg::*;

   entry_type mem [MAX_BLOCKS];

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      rdata <= mem[ram_req.raddr];
   end
endmodule

/* hw/rtl/bba_engine.sv */
// scan, split and query sequencer with the response register
// depends on bba_pkg, bba_req_if, bba_rsp_if and the defines header
`include "buddy_block_allocator_top_defines.svh"
module bba_engine (
   input  logic                 clock,
   input  logic                 reset,
   bba_req_if.sink              req_ch,
   bba_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [4:0]           csr_wdata,
   output bba_pkg::ram_req_type ram_req,
   input  bba_pkg::entry_type   rdata
);
   import bba_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_SRD, ST_SEV, ST_SHRD, ST_SHWR,
      ST_SPL1, ST_SPL2, ST_QRD, ST_QEV, ST_EMIT
   } state_type;

   state_type             st_ff, st_in;
   logic [4:0]            total_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      i_ff;
   logic [IDX_W-1:0]      j_ff;
   logic [4:0]            ord_ff;
   logic [OWNER_BITS-1:0] own_ff;
   logic [30:0]           size_ff;
   status_type            res_status_ff;
   logic [CNT_W-1:0]      res_idx_ff;
   logic [4:0]            res_ord_ff;
   logic [OWNER_BITS-1:0] res_own_ff;
   logic                  res_last_ff;
   logic                  rsp_valid_ff;
   status_type            out_status_ff;
   logic [4:0]            out_idx_ff;
   logic [4:0]            out_ord_ff;
   logic [OWNER_BITS-1:0] out_own_ff;
   logic [5:0]            out_total_ff;
   logic                  out_last_ff;

   logic [OWNER_BITS-1:0] own_cut;
   logic [31:0]           blk_size;
   logic                  too_small;
   logic                  exact;
   logic                  slot_free;

   assign own_cut   = OWNER_BITS'(req_ch.owner_id);
   assign blk_size  = 32'd1 << rdata.order;
   assign too_small = {1'b0, size_ff} > blk_size;
   assign exact     = {size_ff, 1'b0} > blk_size;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready = (st_ff == ST_IDLE);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = out_status_ff;
   assign rsp_ch.block_index = out_idx_ff;
   assign rsp_ch.block_order = out_ord_ff;
   assign rsp_ch.block_owner = 16'(out_own_ff);
   assign rsp_ch.block_total = out_total_ff;
   assign rsp_ch.last        = out_last_ff;

   // memory port
   always_comb begin
      ram_req       = '0;
      ram_req.raddr = (st_ff == ST_SHRD) ? j_ff : i_ff[IDX_W-1:0];
      case (st_ff)
         ST_INIT: begin
            ram_req.we    = 1'b1;
            ram_req.wdata = '{order: total_ff, owner: '0};
         end
         ST_SEV: begin
            if (rdata.owner == '0 && !too_small && exact) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = i_ff[IDX_W-1:0];
               ram_req.wdata = '{order: rdata.order, owner: own_ff};
            end
         end
         ST_SHWR: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = IDX_W'(j_ff + IDX_W'(1));
            ram_req.wdata = rdata;
         end
         ST_SPL1: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = IDX_W'(i_ff + CNT_W'(1));
            ram_req.wdata = '{order: ord_ff - 5'd1, owner: '0};
         end
         ST_SPL2: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = i_ff[IDX_W-1:0];
            ram_req.wdata = '{order: ord_ff - 5'd1, owner: '0};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_INIT: st_in = ST_IDLE;
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.action) st_in = ST_QRD;
               else if (req_ch.request_size == '0 || own_cut == '0) st_in = ST_EMIT;
               else st_in = ST_SRD;
            end
         end
         ST_SRD:  st_in = (i_ff >= cnt_ff) ? ST_EMIT : ST_SEV;
         ST_SEV: begin
            if (rdata.owner != '0 || too_small) st_in = ST_SRD;
            else if (exact) st_in = ST_EMIT;
            else if (cnt_ff == CNT_W'(MAX_BLOCKS)) st_in = ST_EMIT;
            else if (cnt_ff - CNT_W'(1) > i_ff) st_in = ST_SHRD;
            else st_in = ST_SPL1;
         end
         ST_SHRD: st_in = ST_SHWR;
         ST_SHWR: st_in = (CNT_W'(j_ff) == i_ff + CNT_W'(1)) ? ST_SPL1 : ST_SHRD;
         ST_SPL1: st_in = ST_SPL2;
         ST_SPL2: st_in = ST_SRD;
         ST_QRD:  st_in = ST_QEV;
         ST_QEV:  st_in = ST_EMIT;
         ST_EMIT: begin
            if (slot_free) st_in = res_last_ff ? ST_IDLE : ST_QRD;
         end
         default: st_in = ST_IDLE;
      endcase
      if (csr_we) st_in = ST_INIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_INIT;
         total_ff     <= ORDER_RESET;
         cnt_ff       <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         // load on emit, otherwise clear once the word is taken
         if (st_ff == ST_EMIT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            total_ff <= csr_wdata;
         end
         case (st_ff)
            ST_INIT: cnt_ff <= CNT_W'(1);
            ST_IDLE: begin
               i_ff        <= '0;
               own_ff      <= own_cut;
               size_ff     <= req_ch.request_size;
               res_status_ff <= STAT_INVALID;
               res_idx_ff  <= '0;
               res_ord_ff  <= '0;
               res_own_ff  <= '0;
               res_last_ff <= 1'b1;
            end
            ST_SRD: begin
               res_status_ff <= STAT_NO_FIT;
            end
            ST_SEV: begin
               ord_ff <= rdata.order;
               j_ff   <= IDX_W'(cnt_ff - CNT_W'(1));
               if (rdata.owner != '0 || too_small) begin
                  i_ff <= i_ff + CNT_W'(1);
               end else if (exact) begin
                  res_status_ff <= STAT_OK;
                  res_idx_ff    <= i_ff;
                  res_ord_ff    <= rdata.order;
                  res_own_ff    <= own_ff;
               end else begin
                  res_status_ff <= STAT_FULL;
               end
            end
            ST_SHWR: j_ff <= j_ff - IDX_W'(1);
            ST_SPL2: cnt_ff <= cnt_ff + CNT_W'(1);
            ST_QEV: begin
               res_status_ff <= STAT_OK;
               res_idx_ff    <= i_ff;
               res_ord_ff    <= rdata.order;
               res_own_ff    <= rdata.owner;
               res_last_ff   <= (i_ff + CNT_W'(1) == cnt_ff);
            end
            ST_EMIT: begin
               if (slot_free) begin
                  out_status_ff <= res_status_ff;
                  out_idx_ff    <= 5'(res_idx_ff);
                  out_ord_ff    <= res_ord_ff;
                  out_own_ff    <= res_own_ff;
                  out_total_ff  <= 6'(cnt_ff);
                  out_last_ff   <= res_last_ff;
                  i_ff          <= i_ff + CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   `BBA_ASSERT(a_cnt_range, clock, reset, (cnt_ff != '0) && (cnt_ff <= CNT_W'(MAX_BLOCKS)))
   `BBA_ASSERT(a_split_grows, clock, reset, (st_ff == ST_SPL2 && !csr_we) |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
   `BBA_ASSERT(a_load_emit, clock, reset, (st_ff != ST_EMIT && !rsp_valid_ff) |=> !rsp_valid_ff)
endmodule

/* hw/rtl/buddy_block_allocator_top.sv */
// top level of the buddy block allocator: engine plus block list memory
// depends on bba_pkg, bba_req_if, bba_rsp_if, bba_ram, bba_engine
//
// channel   dir  handshake     word
// req_ch    in   valid/ready   action, owner_id, request_size
// rsp_ch    out  valid/ready   status, index, order, owner, total, last
// csr_*     in   write enable  total_order
//
// allocate: read, check per entry; read, write per move; two writes per split
// query: read, check, emit per word, the emit held until the response register is free
// reset and each csr write rewrite entry 0 as one free block, ready low meanwhile
// one response register; a new request is taken while the last word waits
module buddy_block_allocator_top (
   input  logic       clock,
   input  logic       reset,
   bba_req_if.sink    req_ch,
   bba_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic [4:0] csr_wdata
);
   import bba_pkg::*;

   ram_req_type ram_req;
   entry_type   rdata;

   bba_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .ram_req   (ram_req),
      .rdata     (rdata)
   );

   bba_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (rdata)
   );
endmodule
